// ===== rtl/core/xsk_pkg.sv =====
// ----------------------------------------------------------------------------
// xsk_pkg
// Types, constants and the xorshift64 step shared by the keystream cipher.
// ----------------------------------------------------------------------------
package xsk_pkg;

  // xorshift64 shift amounts
  localparam int unsigned XS_SH_A = 13;
  localparam int unsigned XS_SH_B = 7;
  localparam int unsigned XS_SH_C = 17;

  localparam int unsigned KEY_W      = 64;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 64;

  // byte position meaning "word buffer empty"
  localparam logic [POS_W-1:0] BUF_EMPTY = 4'd8;

  // register index decoded from paddr[3] (registers sit on 8-byte steps)
  localparam logic REG_IDX_KEY = 1'b0;

  typedef struct packed {
    logic             load;
    logic [KEY_W-1:0] key;
  } xsk_seed_t;

  typedef struct packed {
    logic busy;   // warm-up steps still running
    logic empty;  // word buffer empty
  } xsk_stat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              end_of_block_out;
  } xsk_res_t;

  function automatic logic [KEY_W-1:0] xs_advance(input logic [KEY_W-1:0] x);
    logic [KEY_W-1:0] y;
    y = x ^ (x << XS_SH_A);
    y = y ^ (y >> XS_SH_B);
    y = y ^ (y << XS_SH_C);
    return y;
  endfunction

endpackage

// ===== rtl/core/xsk_ifs.sv =====
// ----------------------------------------------------------------------------
// xsk_ifs
// Valid/ready channels for input bytes and result bytes.
// ----------------------------------------------------------------------------
interface xsk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_block;

  modport source (output valid, output data_byte, output end_of_block, input ready);
  modport sink   (input valid, input data_byte, input end_of_block, output ready);
endinterface

interface xsk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_block_out;

  modport source (output valid, output out_byte, output end_of_block_out, input ready);
  modport sink   (input valid, input out_byte, input end_of_block_out, output ready);
endinterface

// ===== rtl/core/xsk_gen.sv =====
// ----------------------------------------------------------------------------
// xsk_gen
// xorshift64 generator with warm-up sequencer and 8-byte keystream buffer.
// ----------------------------------------------------------------------------
module xsk_gen
  import xsk_pkg::*;
#(
  parameter int WARMUP_STEPS = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  xsk_seed_t         seed,
  input  logic              adv,
  output xsk_stat_t         stat,
  output logic [BYTE_W-1:0] ks_byte
);

  localparam int CNT_W = $clog2(WARMUP_STEPS + 2);

  logic [KEY_W-1:0] gen_r;
  logic [KEY_W-1:0] ks_r;
  logic [POS_W-1:0] pos_r;
  logic [CNT_W-1:0] cnt_r;
  logic [KEY_W-1:0] step;
  logic             empty;

  assign step  = xs_advance(gen_r);
  assign empty = pos_r[POS_W-1];  // 8..15 all count as empty

  always_comb begin
    if (empty) begin
      ks_byte = step[BYTE_W-1:0];
    end else begin
      ks_byte = ks_r[{pos_r[2:0], 3'b000} +: BYTE_W];
    end
  end

  assign stat.busy  = (cnt_r != '0);
  assign stat.empty = empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= '0;
      ks_r  <= '0;
      pos_r <= BUF_EMPTY;
      cnt_r <= CNT_W'(WARMUP_STEPS);
    end else if (seed.load) begin
      gen_r <= seed.key;
      ks_r  <= '0;
      pos_r <= BUF_EMPTY;
      cnt_r <= CNT_W'(WARMUP_STEPS);
    end else if (cnt_r != '0) begin
      // warm-up: one step a cycle
      gen_r <= step;
      cnt_r <= cnt_r - 1'b1;
    end else if (adv) begin
      if (empty) begin
        gen_r <= step;
        ks_r  <= step;
        pos_r <= POS_W'(1);
      end else begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/xsk_obuf.sv =====
// ----------------------------------------------------------------------------
// xsk_obuf
// Two-entry result buffer; keeps full rate while the sink is ready.
// ----------------------------------------------------------------------------
module xsk_obuf
  import xsk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  xsk_res_t   push_data,
  output logic       full,
  xsk_out_if.source  out_ch
);

  xsk_res_t   mem_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign full   = (cnt_r == 2'd2);
  assign pop    = out_ch.valid && out_ch.ready;

  assign out_ch.valid            = (cnt_r != 2'd0);
  assign out_ch.out_byte         = mem_r[rd_r].out_byte;
  assign out_ch.end_of_block_out = mem_r[rd_r].end_of_block_out;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/xorshift_keystream_byte_cipher.sv =====
// ----------------------------------------------------------------------------
// xorshift_keystream_byte_cipher
// Byte stream cipher: each byte is XORed with the next xorshift64 keystream
// byte, least significant first, eight bytes per generator word.
// ----------------------------------------------------------------------------
// One byte per clock is taken while in_beat.ready is high, and its result is
// registered in a two-entry output buffer, so the input keeps running while
// the sink stalls until both entries are occupied. After reset or a write to
// the 64-bit key register at byte address 0, the generator runs WARMUP_STEPS
// steps, one per cycle, with in_beat.ready low meanwhile. Encryption and
// decryption are the same operation; end_of_block is passed through and does
// not touch the keystream. A zero key gives an all-zero keystream.
module xorshift_keystream_byte_cipher
  import xsk_pkg::*;
#(
  parameter int WARMUP_STEPS = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  xsk_in_if.sink                in_beat,
  xsk_out_if.source             out_beat,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [KEY_W-1:0]  key_r;
  logic              cfg_wr;
  xsk_seed_t         seed;
  xsk_stat_t         stat;
  logic [BYTE_W-1:0] ks_byte;
  logic              buf_full;
  logic              in_acc;
  xsk_res_t          res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[3] == REG_IDX_KEY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_wr) begin
      key_r <= cfg_pwdata;
    end
  end

  always_comb begin
    if (cfg_paddr[3] == REG_IDX_KEY) begin
      cfg_prdata = key_r;
    end else begin
      cfg_prdata = '0;
    end
  end

  assign seed.load = cfg_wr;
  assign seed.key  = cfg_pwdata;

  assign in_beat.ready = !stat.busy && !buf_full;
  assign in_acc        = in_beat.valid && in_beat.ready;

  xsk_gen #(
    .WARMUP_STEPS (WARMUP_STEPS)
  ) u_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .seed    (seed),
    .adv     (in_acc),
    .stat    (stat),
    .ks_byte (ks_byte)
  );

  assign res.out_byte         = in_beat.data_byte ^ ks_byte;
  assign res.end_of_block_out = in_beat.end_of_block;

  xsk_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (res),
    .full      (buf_full),
    .out_ch    (out_beat)
  );

`ifndef ASSERT_OFF
  a_no_beat_in_warmup: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !stat.busy)
    else $error("input beat taken during warm-up");

  a_key_empties_buf: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> stat.empty)
    else $error("key write did not empty the word buffer");

  a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_beat.valid)
    else $error("accepted beat produced no result");

  a_warmup_after_key: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> ((WARMUP_STEPS == 0) || stat.busy))
    else $error("key write did not start warm-up");
`endif

endmodule
